// ===== sv/assert_macros.svh =====
// Assertion helpers included by the allocator unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BSA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bsa_pkg.sv =====
package bsa_pkg;

   localparam int WORD_W      = 32;
   localparam int WORD_BIT_W  = 5;
   localparam int ADDR_W      = 32;
   localparam int SHIFT_W     = 5;
   localparam int COUNT_W     = 9;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;

   localparam logic [SHIFT_W-1:0] MAX_SHIFT = 5'd16;

   localparam logic [ADDR_W-1:0]  POOL_BASE_RESET  = 32'd0;
   localparam logic [SHIFT_W-1:0] OBJ_SHIFT_RESET  = 5'd4;
   localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = 9'd256;

   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_BASE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OBJ_SHIFT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_COUNT = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_CHECK,
      ST_ALLOC_ADDR,
      ST_FREE_SUB,
      ST_FREE_CHECK,
      ST_FREE_WRITE,
      ST_DONE
   } bsa_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } bsa_map_ctl_type;

endpackage

// ===== sv/bsa_bitmap.sv =====
module bsa_bitmap #(
   parameter int WORDS = 8,
   localparam int MAP_ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bsa_pkg::bsa_map_ctl_type       map_ctl,
   input  logic [MAP_ADDR_W-1:0]          rd_addr,
   input  logic [MAP_ADDR_W-1:0]          wr_addr,
   input  logic [bsa_pkg::WORD_W-1:0]     wr_data,
   output logic [bsa_pkg::WORD_W-1:0]     rd_data
);
   import bsa_pkg::*;

   logic [WORD_W-1:0] map_ff [WORDS];
   logic [WORDS-1:0]  row_valid_ff;
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (map_ctl.wr_en) begin
         map_ff[wr_addr] <= wr_data;
      end
   end

   // a row never written reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (map_ctl.wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (map_ctl.rd_en) begin
         rd_data_ff <= row_valid_ff[rd_addr] ? map_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bitmap_slab_allocator_unit.sv =====
// Channel   | Direction | Handshake           | Payload
// req_      | in        | req_valid/req_stall | req_action, req_free_address
// rsp_      | out       | rsp_valid/rsp_stall | rsp_address, rsp_status
// csr_      | in        | csr_write_enable    | csr_index, csr_write_data
//
// Allocate: accept, then scan the 32-slot map words in turn (up to ceil(capacity/32)),
// then form the address and post it; a full pool posts its result straight after the scan.
// Free: accept, subtract, check, read-modify-write, post; a rejected free skips the write.
// Synchronous reset clears the whole map at once through per-word valid bits.
// A stalled result holds in the output register; the next transaction is
// taken meanwhile and waits in its last step until the register frees.
`include "assert_macros.svh"

module bitmap_slab_allocator_unit #(
   parameter int SLOTS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [bsa_pkg::ADDR_W-1:0]          req_free_address,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bsa_pkg::ADDR_W-1:0]          rsp_address,
   output logic [bsa_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                csr_write_enable,
   input  logic [bsa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bsa_pkg::WORD_W-1:0]          csr_write_data
);
   import bsa_pkg::*;

   localparam int WORDS  = (SLOTS + WORD_W - 1) / WORD_W;
   localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int WC_W   = $clog2(WORDS + 1);
   localparam int CAP_W  = $clog2(SLOTS + 1);
   localparam int BASE_W = WC_W + WORD_BIT_W;

   bsa_state_type state_ff, state_in;

   logic [ADDR_W-1:0]   pool_base_ff;
   logic [SHIFT_W-1:0]  obj_shift_ff;
   logic [COUNT_W-1:0]  slot_count_ff;

   logic [WC_W-1:0]       word_ff, word_in;
   logic [WORD_BIT_W-1:0] bit_ff, bit_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [ADDR_W-1:0]     off_ff, off_in;
   logic                  below_ff, below_in;
   logic [ADDR_W-1:0]     res_addr_ff, res_addr_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_address_ff, rsp_address_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [SHIFT_W-1:0] shift;
   logic [CAP_W-1:0]   cap;

   // shared adder
   logic [ADDR_W-1:0] add_a, add_b;
   logic              add_sub;
   logic [ADDR_W:0]   add_sum;

   // map port
   bsa_map_ctl_type   map_ctl;
   logic [WA_W-1:0]   rd_addr, wr_addr;
   logic [WORD_W-1:0] wr_data, rd_data;

   // scan
   logic [BASE_W-1:0]     scan_base, next_base, rem;
   logic [WORD_W-1:0]     lane_mask, avail;
   logic                  hit, at_end;
   logic [WORD_BIT_W-1:0] hit_bit;

   // free decode
   logic [ADDR_W-1:0] off_idx, low_mask;
   logic              free_ok;

   assign shift = (obj_shift_ff > MAX_SHIFT) ? MAX_SHIFT : obj_shift_ff;
   assign cap   = (32'(slot_count_ff) > 32'(SLOTS)) ? CAP_W'(SLOTS) : CAP_W'(slot_count_ff);

   assign add_sum = {1'b0, add_a} + {1'b0, add_b ^ {ADDR_W{add_sub}}} + (ADDR_W + 1)'(add_sub);

   assign scan_base = {word_ff, {WORD_BIT_W{1'b0}}};
   assign next_base = scan_base + BASE_W'(WORD_W);
   assign at_end    = next_base >= BASE_W'(cap);
   assign rem       = BASE_W'(cap) - scan_base;
   assign lane_mask = (rem >= BASE_W'(WORD_W)) ? '1
                      : ((WORD_W'(1) << rem[WORD_BIT_W-1:0]) - WORD_W'(1));
   assign avail     = ~rd_data & lane_mask;
   assign hit       = |avail;

   always_comb begin
      hit_bit = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (avail[b]) begin
            hit_bit = WORD_BIT_W'(b);
         end
      end
   end

   assign off_idx  = off_ff >> shift;
   assign low_mask = (ADDR_W'(1) << shift) - ADDR_W'(1);
   assign free_ok  = !below_ff && ((off_ff & low_mask) == '0)
                     && (off_idx < ADDR_W'(cap));

   bsa_bitmap #(
      .WORDS (WORDS)
   ) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .map_ctl (map_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff  <= POOL_BASE_RESET;
         obj_shift_ff  <= OBJ_SHIFT_RESET;
         slot_count_ff <= SLOT_COUNT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_POOL_BASE:  pool_base_ff  <= csr_write_data;
            CSR_OBJ_SHIFT:  obj_shift_ff  <= csr_write_data[SHIFT_W-1:0];
            CSR_SLOT_COUNT: slot_count_ff <= csr_write_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff        <= word_in;
      bit_ff         <= bit_in;
      addr_ff        <= addr_in;
      off_ff         <= off_in;
      below_ff       <= below_in;
      res_addr_ff    <= res_addr_in;
      res_status_ff  <= res_status_in;
      rsp_address_ff <= rsp_address_in;
      rsp_status_ff  <= rsp_status_in;
   end

   always_comb begin
      state_in       = state_ff;
      word_in        = word_ff;
      bit_in         = bit_ff;
      addr_in        = addr_ff;
      off_in         = off_ff;
      below_in       = below_ff;
      res_addr_in    = res_addr_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_address_in = rsp_address_ff;
      rsp_status_in  = rsp_status_ff;
      map_ctl        = '0;
      rd_addr        = '0;
      wr_addr        = word_ff[WA_W-1:0];
      wr_data        = rd_data | (WORD_W'(1) << hit_bit);
      add_a          = pool_base_ff;
      add_b          = ADDR_W'({word_ff, bit_ff}) << shift;
      add_sub        = 1'b0;

      // drain the output register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               addr_in = req_free_address;
               if (req_action == ACTION_FREE) begin
                  state_in = ST_FREE_SUB;
               end else begin
                  word_in       = '0;
                  map_ctl.rd_en = 1'b1;
                  state_in      = ST_ALLOC_CHECK;
               end
            end
         end
         ST_ALLOC_CHECK: begin
            if (hit) begin
               bit_in        = hit_bit;
               map_ctl.wr_en = 1'b1;
               state_in      = ST_ALLOC_ADDR;
            end else if (at_end) begin
               res_addr_in   = '0;
               res_status_in = STATUS_FULL;
               state_in      = ST_DONE;
            end else begin
               // fetch the next word while this one is judged
               word_in       = word_ff + WC_W'(1);
               rd_addr       = WA_W'(word_ff + WC_W'(1));
               map_ctl.rd_en = 1'b1;
            end
         end
         ST_ALLOC_ADDR: begin
            res_addr_in   = add_sum[ADDR_W-1:0];
            res_status_in = STATUS_OK;
            state_in      = ST_DONE;
         end
         ST_FREE_SUB: begin
            add_a    = addr_ff;
            add_b    = pool_base_ff;
            add_sub  = 1'b1;
            off_in   = add_sum[ADDR_W-1:0];
            below_in = !add_sum[ADDR_W];
            state_in = ST_FREE_CHECK;
         end
         ST_FREE_CHECK: begin
            res_addr_in = '0;
            if (free_ok) begin
               word_in       = WC_W'(off_idx[WORD_BIT_W +: WA_W]);
               bit_in        = off_idx[WORD_BIT_W-1:0];
               rd_addr       = off_idx[WORD_BIT_W +: WA_W];
               map_ctl.rd_en = 1'b1;
               state_in      = ST_FREE_WRITE;
            end else begin
               res_status_in = STATUS_BAD;
               state_in      = ST_DONE;
            end
         end
         ST_FREE_WRITE: begin
            wr_data       = rd_data & ~(WORD_W'(1) << bit_ff);
            map_ctl.wr_en = 1'b1;
            res_status_in = STATUS_OK;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_address_in = res_addr_ff;
               rsp_status_in  = res_status_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_address_ff;
   assign rsp_status  = rsp_status_ff;

   `BSA_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, state_ff != ST_IDLE, "accepted transaction left the sequencer idle")
   `BSA_ASSERT_IMPLY(a_fail_addr_zero, clock, reset, rsp_valid_ff && (rsp_status_ff != STATUS_OK) , rsp_address_ff == '0, "failed transaction returned a nonzero address")
   `BSA_ASSERT_IMPLY(a_scan_in_cap, clock, reset, state_ff == ST_ALLOC_CHECK, (scan_base < BASE_W'(cap)) || (cap == '0), "scan word beyond capacity")
   `BSA_ASSERT_IMPLY(a_map_no_rw_clash, clock, reset, map_ctl.wr_en, !(map_ctl.rd_en && (rd_addr == wr_addr)), "map read and write hit the same word")

endmodule

// ===== tb/sv/tb_bitmap_slab_allocator_unit.sv =====
module tb_bitmap_slab_allocator_unit;
   localparam int SLOT_TOTAL    = 256;
   localparam int RUN_LIMIT     = 5_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 130;
   localparam logic [bsa_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [bsa_pkg::ADDR_W-1:0]   address;
      logic [bsa_pkg::STATUS_W-1:0] status;
   } slab_result_type;

   class slab_scoreboard;
      logic [bsa_pkg::ADDR_W-1:0]  pool_base;
      logic [bsa_pkg::SHIFT_W-1:0] size_log2;
      logic [bsa_pkg::COUNT_W-1:0] slot_count;
      bit                          used_slot [SLOT_TOTAL];
      slab_result_type             expected [$];
      int                          mismatches;
      int                          checked;
      int                          alloc_ok;
      int                          alloc_full;
      int                          free_ok;
      int                          free_bad;

      function new();
         pool_base  = bsa_pkg::POOL_BASE_RESET;
         size_log2  = bsa_pkg::OBJ_SHIFT_RESET;
         slot_count = bsa_pkg::SLOT_COUNT_RESET;
         foreach (used_slot[i]) used_slot[i] = 1'b0;
      endfunction

      function int eff_shift();
         return (size_log2 > bsa_pkg::MAX_SHIFT) ? int'(bsa_pkg::MAX_SHIFT) : int'(size_log2);
      endfunction

      function int eff_capacity();
         return (slot_count > SLOT_TOTAL) ? SLOT_TOTAL : int'(slot_count);
      endfunction

      function void set_register(logic [bsa_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [bsa_pkg::WORD_W-1:0] data);
         case (idx)
            bsa_pkg::CSR_POOL_BASE:  pool_base  = data[bsa_pkg::ADDR_W-1:0];
            bsa_pkg::CSR_OBJ_SHIFT:  size_log2  = data[bsa_pkg::SHIFT_W-1:0];
            bsa_pkg::CSR_SLOT_COUNT: slot_count = data[bsa_pkg::COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // Predict the outcome of an accepted request and queue it.
      function slab_result_type note_request(logic act, logic [bsa_pkg::ADDR_W-1:0] addr);
         slab_result_type            res;
         int                         shift;
         int                         cap;
         int                         slot;
         logic [bsa_pkg::ADDR_W-1:0] offset;
         logic [bsa_pkg::ADDR_W-1:0] index;
         shift       = eff_shift();
         cap         = eff_capacity();
         res.address = '0;
         if (act == bsa_pkg::ACTION_ALLOC) begin
            res.status = bsa_pkg::STATUS_FULL;
            for (slot = 0; slot < cap; slot++) begin
               if (!used_slot[slot]) begin
                  used_slot[slot] = 1'b1;
                  res.address     = pool_base + (32'(slot) << shift);
                  res.status      = bsa_pkg::STATUS_OK;
                  break;
               end
            end
            if (res.status == bsa_pkg::STATUS_OK) alloc_ok++;
            else alloc_full++;
         end else begin
            res.status = bsa_pkg::STATUS_BAD;
            if (addr >= pool_base) begin
               offset = addr - pool_base;
               index  = offset >> shift;
               if ((offset & ((32'd1 << shift) - 32'd1)) == '0 && index < 32'(cap)) begin
                  used_slot[index] = 1'b0;
                  res.status       = bsa_pkg::STATUS_OK;
               end
            end
            if (res.status == bsa_pkg::STATUS_OK) free_ok++;
            else free_bad++;
         end
         expected.push_back(res);
         return res;
      endfunction

      function void check_response(logic [bsa_pkg::ADDR_W-1:0] addr,
                                   logic [bsa_pkg::STATUS_W-1:0] status);
         slab_result_type want;
         checked++;
         if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch %0d: unexpected transaction, address %h status %0d",
                        mismatches, addr, status);
            return;
         end
         want = expected.pop_front();
         if (addr !== want.address || status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch %0d: expected address %h status %0d, got address %h status %0d",
                        mismatches, want.address, want.status, addr, status);
         end
      endfunction

      function int pending();
         return expected.size();
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic                            req_action;
   logic [bsa_pkg::ADDR_W-1:0]      req_free_address;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [bsa_pkg::ADDR_W-1:0]      rsp_address;
   logic [bsa_pkg::STATUS_W-1:0]    rsp_status;
   logic                            csr_write_enable;
   logic [bsa_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [bsa_pkg::WORD_W-1:0]      csr_write_data;

   slab_scoreboard               sb = new();
   slab_result_type              last_result;
   bit                           calm;
   bit                           rsp_taken;
   int                           phases_run;

   bitmap_slab_allocator_unit #(.SLOTS(SLOT_TOTAL)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_free_address (req_free_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_address      (rsp_address),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #RUN_LIMIT;
      $display("timeout with %0d transactions outstanding", sb.pending());
      $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_address, rsp_status);
         rsp_taken = 1'b1;
      end
   end

   // Hold off the result side for a random number of cycles after each transaction, except in calm phases.
   initial begin
      int hold;
      hold      = 0;
      rsp_stall = 1'b0;
      rsp_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            hold      = calm ? 0 : $urandom_range(0, 12);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic issue_request(input logic act, input logic [bsa_pkg::ADDR_W-1:0] addr);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= act;
      req_free_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      last_result = sb.note_request(act, addr);
      @(negedge clock);
   endtask

   task automatic drain();
      int waited;
      waited    = 0;
      req_valid <= 1'b0;
      while (sb.pending() != 0 && waited < 4000) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input logic [31:0] base, input logic [31:0] shift_word,
                            input logic [31:0] count_word, input bit with_spare);
      logic [bsa_pkg::CSR_INDEX_W-1:0] idx [4];
      logic [bsa_pkg::WORD_W-1:0]      val [4];
      int                              n;
      idx = '{bsa_pkg::CSR_POOL_BASE, bsa_pkg::CSR_OBJ_SHIFT, bsa_pkg::CSR_SLOT_COUNT,
              CSR_SPARE};
      val = '{base, shift_word, count_word, $urandom};
      n   = with_spare ? 4 : 3;
      for (int k = 0; k < n; k++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= idx[k];
         csr_write_data   <= val[k];
         @(negedge clock);
         sb.set_register(idx[k], val[k]);
      end
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [31:0] live [$];
      logic [31:0] base;
      logic [31:0] shift_word;
      logic [31:0] count_word;
      logic [31:0] addr;
      int          shift_sel;
      int          cap_now;
      int          shift_now;
      int          pick;
      int          pos;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = bsa_pkg::ACTION_ALLOC;
      req_free_address = '0;
      csr_write_enable = 1'b0;
      csr_index        = bsa_pkg::CSR_POOL_BASE;
      csr_write_data   = '0;
      calm             = 1'b0;
      phases_run       = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset defaults: base 0, 16-byte objects, full capacity.
      issue_request(bsa_pkg::ACTION_ALLOC, 32'hFFFF_FFFF);
      issue_request(bsa_pkg::ACTION_ALLOC, 32'h0000_0000);
      issue_request(bsa_pkg::ACTION_FREE, 32'h0000_0010);
      issue_request(bsa_pkg::ACTION_FREE, 32'h0000_0008);
      issue_request(bsa_pkg::ACTION_FREE, 32'h0000_1000);
      issue_request(bsa_pkg::ACTION_FREE, 32'hFFFF_FFFF);
      issue_request(bsa_pkg::ACTION_FREE, 32'h0000_0000);
      drain();

      // Small pool: fill it, overflow, double free, bad addresses.
      configure(32'h0000_1000, 32'd4, 32'd4, 1'b1);
      repeat (5) issue_request(bsa_pkg::ACTION_ALLOC, $urandom);
      issue_request(bsa_pkg::ACTION_FREE, 32'h0000_1010);
      issue_request(bsa_pkg::ACTION_FREE, 32'h0000_1010);
      issue_request(bsa_pkg::ACTION_FREE, 32'h0000_0FF0);
      issue_request(bsa_pkg::ACTION_FREE, 32'h0000_1040);
      issue_request(bsa_pkg::ACTION_ALLOC, $urandom);
      drain();

      // Shrink capacity under used slots.
      configure(32'h0000_1000, 32'd4, 32'd2, 1'b0);
      issue_request(bsa_pkg::ACTION_FREE, 32'h0000_1020);
      issue_request(bsa_pkg::ACTION_ALLOC, $urandom);
      drain();
      configure(32'h0000_1000, 32'd4, 32'd0, 1'b0);
      issue_request(bsa_pkg::ACTION_ALLOC, $urandom);
      drain();

      // Oversized shift and count, with the address wrapping past zero.
      configure(32'hFFFF_0000, 32'd31, 32'd511, 1'b0);
      issue_request(bsa_pkg::ACTION_ALLOC, $urandom);
      issue_request(bsa_pkg::ACTION_FREE, last_result.address);
      issue_request(bsa_pkg::ACTION_FREE, 32'hFFFF_8000);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            base = 32'hFFFF_FF00; shift_word = 32'd0; count_word = 32'd256;
         end else if (p == 1) begin
            base = 32'h0000_0000; shift_word = 32'd16; count_word = 32'd511;
         end else begin
            shift_sel = $urandom_range(0, 9);
            case (shift_sel)
               0:       shift_word = 32'd0;
               1:       shift_word = 32'd16;
               2:       shift_word = $urandom_range(17, 31);
               default: shift_word = $urandom_range(1, 15);
            endcase
            shift_now = (shift_word > 16) ? 16 : int'(shift_word);
            base      = $urandom;
            if ($urandom_range(0, 3) != 0) base = base & ~((32'd1 << shift_now) - 32'd1);
            case ($urandom_range(0, 9))
               0:       count_word = 32'd0;
               1:       count_word = 32'd256;
               2:       count_word = $urandom_range(257, 511);
               3:       count_word = $urandom_range(41, 255);
               default: count_word = $urandom_range(1, 40);
            endcase
            // Upper bits beyond the register width are dropped.
            if ($urandom_range(0, 2) == 0) begin
               shift_word = shift_word | ($urandom & 32'hFFFF_FFE0);
               count_word = count_word | ($urandom & 32'hFFFF_FE00);
            end
         end
         configure(base, shift_word, count_word, $urandom_range(0, 5) == 0);
         calm      = ($urandom_range(0, 3) == 0);
         shift_now = sb.eff_shift();
         cap_now   = sb.eff_capacity();
         live.delete();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50 || (pick < 80 && live.size() == 0)) begin
               issue_request(bsa_pkg::ACTION_ALLOC, $urandom);
               if (last_result.status == bsa_pkg::STATUS_OK) live.push_back(last_result.address);
            end else if (pick < 80) begin
               pos  = $urandom_range(0, live.size() - 1);
               addr = live[pos];
               live.delete(pos);
               issue_request(bsa_pkg::ACTION_FREE, addr);
            end else if (pick < 90) begin
               addr = base + (32'($urandom_range(0, cap_now + 1)) << shift_now);
               issue_request(bsa_pkg::ACTION_FREE, addr);
            end else begin
               case ($urandom_range(0, 2))
                  0:       addr = $urandom;
                  1:       addr = base + $urandom_range(1, 255);
                  default: addr = base - 32'd1;
               endcase
               issue_request(bsa_pkg::ACTION_FREE, addr);
            end
         end
         drain();
         phases_run++;
      end

      calm = 1'b0;
      drain();
      if (sb.pending() != 0)
         $display("%0d expected transactions never arrived", sb.pending());
      $display("covered %0d configurations, %0d results checked, %0d mismatches",
               phases_run + 5, sb.checked, sb.mismatches);
      $display("allocs ok %0d, pool full %0d, frees ok %0d, bad frees %0d",
               sb.alloc_ok, sb.alloc_full, sb.free_ok, sb.free_bad);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== bitmap_slab_allocator_unit.f =====
+incdir+sv
sv/bsa_pkg.sv
sv/bsa_bitmap.sv
sv/bitmap_slab_allocator_unit.sv
tb/sv/tb_bitmap_slab_allocator_unit.sv
